// File: design/mvn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_pkg
// Shared types and constants for the mesh vertex normal engine.
// ----------------------------------------------------------------------------
package mvn_pkg;

    localparam int VERTEX_SLOTS_DEF = 1024;

    localparam int COORD_W  = 20;
    localparam int DIFF_W   = 21;
    localparam int PROD_W   = 42;
    localparam int CROSS_W  = 43;
    localparam int MAG_W    = 44;
    localparam int NORM_W   = 16;
    localparam int SUM_W    = 23;
    localparam int CNT_W    = 8;
    localparam int SUMREC_W = 3 * SUM_W + CNT_W;
    localparam int COORDREC_W = 3 * COORD_W;
    localparam int UNIT_ONE = 16384;

    localparam int CROSS_STEPS = 6;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 17;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_LOAD     = 2'd1,
        CMD_TRIANGLE = 2'd2,
        CMD_READ     = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LATCH,
        OP_LOAD,
        OP_COORD,
        OP_DIFF,
        OP_CROSS,
        OP_ABS,
        OP_MAX,
        OP_SHIFT,
        OP_SQ,
        OP_SQRT,
        OP_DIV,
        OP_SET_ZERO,
        OP_RDSUM,
        OP_ACC,
        OP_EMIT,
        OP_EMIT_ZERO
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] sel;
        logic [5:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic idx_ok;
        logic crn_ok;
        logic cnt_zero;
        logic max_zero;
        logic shift_done;
        logic len_zero;
    } t_dp_sts;

endpackage

// File: design/mvn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/mvn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_ctrl
// Controller state machine that sequences the datapath for each transaction.
// ----------------------------------------------------------------------------
module mvn_ctrl
    import mvn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_command,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd,
    output logic       busy
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_TCHK, S_COORD, S_DIFF, S_CROSS, S_ABS,
        S_MAX, S_SHIFT, S_SQ, S_SQRT, S_LCHK, S_DIV, S_ACC, S_EMIT,
        S_RCHK, S_RWAIT, S_RCNT
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_step, n_step;
    logic [1:0] r_sel, n_sel;
    logic       r_busy;
    t_dp_cmd    cmd;

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_sel    = r_sel;
        cmd.op   = OP_NONE;
        cmd.sel  = r_sel;
        cmd.step = r_step;
        case (r_state)
            S_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_step = '0;
                n_sel  = '0;
                if (start) begin
                    cmd.op = OP_LATCH;
                    case (t_cmd'(i_command))
                        CMD_CLEAR:    n_state = S_CLEAR;
                        CMD_LOAD:     n_state = S_LOAD;
                        CMD_TRIANGLE: n_state = S_TCHK;
                        CMD_READ:     n_state = S_RCHK;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                cmd.op  = OP_LOAD;
                n_state = S_IDLE;
            end
            S_TCHK: begin
                if (!i_sts.crn_ok) begin
                    cmd.op  = OP_EMIT_ZERO;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_COORD;
                end
            end
            S_COORD: begin
                cmd.op = OP_COORD;
                n_step = r_step + 6'd1;
                if (r_step == 6'd3) begin
                    n_step  = '0;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                cmd.op  = OP_DIFF;
                n_state = S_CROSS;
            end
            S_CROSS: begin
                cmd.op = OP_CROSS;
                n_step = r_step + 6'd1;
                if (r_step == 6'(CROSS_STEPS)) begin
                    n_step  = '0;
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                cmd.op  = OP_ABS;
                cmd.sel = 2'd0;
                n_state = S_MAX;
            end
            S_MAX: begin
                cmd.op  = OP_MAX;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_sts.max_zero) begin
                    cmd.op  = OP_SET_ZERO;
                    n_state = i_sts.is_read ? S_EMIT : S_ACC;
                end else if (!i_sts.shift_done) begin
                    cmd.op = OP_SHIFT;
                end else begin
                    n_step  = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                cmd.op = OP_SQ;
                n_step = r_step + 6'd1;
                if (r_step == 6'd3) begin
                    n_step  = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                cmd.op = OP_SQRT;
                n_step = r_step + 6'd1;
                if (r_step == 6'(SQRT_STEPS)) begin
                    n_step  = '0;
                    n_state = S_LCHK;
                end
            end
            S_LCHK: begin
                n_sel = '0;
                if (i_sts.len_zero) begin
                    cmd.op  = OP_SET_ZERO;
                    n_state = i_sts.is_read ? S_EMIT : S_ACC;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                cmd.op = OP_DIV;
                n_step = r_step + 6'd1;
                if (r_step == 6'(DIV_STEPS)) begin
                    n_step = '0;
                    n_sel  = r_sel + 2'd1;
                    if (r_sel == 2'd2) begin
                        n_sel   = '0;
                        n_state = i_sts.is_read ? S_EMIT : S_ACC;
                    end
                end
            end
            S_ACC: begin
                cmd.op = OP_ACC;
                n_step = r_step + 6'd1;
                if (r_step == 6'd1) begin
                    n_step = '0;
                    n_sel  = r_sel + 2'd1;
                    if (r_sel == 2'd2) begin
                        n_sel   = '0;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                cmd.op  = OP_EMIT;
                n_state = S_IDLE;
            end
            S_RCHK: begin
                if (!i_sts.idx_ok) begin
                    cmd.op  = OP_EMIT_ZERO;
                    n_state = S_IDLE;
                end else begin
                    cmd.op  = OP_RDSUM;
                    n_state = S_RWAIT;
                end
            end
            S_RWAIT: begin
                cmd.op  = OP_ABS;
                cmd.sel = 2'd1;
                n_state = S_RCNT;
            end
            S_RCNT: begin
                if (i_sts.cnt_zero) begin
                    cmd.op  = OP_EMIT_ZERO;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MAX;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
            r_sel   <= '0;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sel   <= n_sel;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd = cmd;
    assign busy  = r_busy;

endmodule

// File: design/mvn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_datapath
// Vertex and sum stores, cross product, normalization and accumulation.
// ----------------------------------------------------------------------------
module mvn_datapath
    import mvn_pkg::*;
#(
    parameter int VERTEX_SLOTS = VERTEX_SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic [1:0]                i_command,
    input  logic [9:0]                i_vertex_index,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    input  logic [10:0]               i_corner_a,
    input  logic [10:0]               i_corner_b,
    input  logic [10:0]               i_corner_c,
    output t_dp_sts                   o_sts,
    output logic                      o_valid,
    output logic                      o_result_kind,
    output logic signed [NORM_W-1:0]  o_normal_x,
    output logic signed [NORM_W-1:0]  o_normal_y,
    output logic signed [NORM_W-1:0]  o_normal_z,
    output logic [CNT_W-1:0]          o_use_count,
    output logic                      o_zero_length
);

    localparam int AW = $clog2(VERTEX_SLOTS);

    logic                      r_kind_read;
    logic [9:0]                r_idx;
    logic [10:0]               r_crn [3];
    logic signed [COORD_W-1:0] r_in_c [3];
    logic signed [COORD_W-1:0] r_pt [3][3];
    logic signed [DIFF_W-1:0]  r_v1 [3];
    logic signed [DIFF_W-1:0]  r_v2 [3];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [CROSS_W-1:0] r_c [3];
    logic [MAG_W-1:0]          r_m [3];
    logic                      r_neg [3];
    logic [MAG_W-1:0]          r_max;
    logic [59:0]               r_sqp;
    logic [61:0]               r_sq;
    logic [62:0]               r_x, r_res, r_bit;
    logic [45:0]               r_rem;
    logic [46:0]               r_dvs;
    logic [15:0]               r_q;
    logic signed [NORM_W-1:0]  r_n [3];
    logic                      r_zl;
    logic [CNT_W-1:0]          r_cnt;
    logic [AW-1:0]             r_clr_addr;

    logic                      r_valid;
    logic                      r_o_kind;
    logic signed [NORM_W-1:0]  r_o_n [3];
    logic [CNT_W-1:0]          r_o_cnt;
    logic                      r_o_zl;

    logic                      c_we;
    logic [AW-1:0]             c_waddr, c_raddr;
    logic [COORDREC_W-1:0]     c_wdata, c_rdata;
    logic                      s_we;
    logic [AW-1:0]             s_waddr, s_raddr;
    logic [SUMREC_W-1:0]       s_wdata, s_rdata;

    logic                      idx_ok, crn_ok;
    logic [10:0]               crn_sel;
    logic [AW-1:0]             crn_addr;
    logic signed [DIFF_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [SUM_W-1:0]   sum_old [3];
    logic signed [SUM_W-1:0]   sum_new [3];
    logic [CNT_W-1:0]          cnt_new;
    logic [31:0]               len;
    logic [15:0]               q_clamp;
    logic [62:0]               rb_sum;
    logic [5:0]                acc_idx;

    assign idx_ok = (32'(r_idx) < 32'(VERTEX_SLOTS));
    assign crn_ok = (r_crn[0] != 11'd0) && (32'(r_crn[0]) <= 32'(VERTEX_SLOTS))
                 && (r_crn[1] != 11'd0) && (32'(r_crn[1]) <= 32'(VERTEX_SLOTS))
                 && (r_crn[2] != 11'd0) && (32'(r_crn[2]) <= 32'(VERTEX_SLOTS));

    always_comb begin
        if (i_cmd.op == OP_COORD) begin
            case (i_cmd.step[1:0])
                2'd0:    crn_sel = r_crn[0];
                2'd1:    crn_sel = r_crn[1];
                default: crn_sel = r_crn[2];
            endcase
        end else begin
            case (i_cmd.sel)
                2'd0:    crn_sel = r_crn[0];
                2'd1:    crn_sel = r_crn[1];
                default: crn_sel = r_crn[2];
            endcase
        end
    end

    assign crn_addr = AW'(crn_sel - 11'd1);
    assign len      = r_res[31:0];
    assign rb_sum   = r_res + r_bit;

    always_comb begin
        case (i_cmd.step[2:0])
            3'd0:    begin mul_a = r_v1[1]; mul_b = r_v2[2]; end
            3'd1:    begin mul_a = r_v2[1]; mul_b = r_v1[2]; end
            3'd2:    begin mul_a = r_v2[0]; mul_b = r_v1[2]; end
            3'd3:    begin mul_a = r_v1[0]; mul_b = r_v2[2]; end
            3'd4:    begin mul_a = r_v1[0]; mul_b = r_v2[1]; end
            default: begin mul_a = r_v2[0]; mul_b = r_v1[1]; end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        logic signed [SUM_W:0] t;
        for (int i = 0; i < 3; i++) begin
            sum_old[i] = s_rdata[i*SUM_W +: SUM_W];
            t = (SUM_W+1)'(sum_old[i]) + (SUM_W+1)'(r_n[i]);
            if (t[SUM_W] != t[SUM_W-1]) begin
                sum_new[i] = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                sum_new[i] = t[SUM_W-1:0];
            end
        end
        cnt_new = (s_rdata[SUMREC_W-1 -: CNT_W] == {CNT_W{1'b1}})
                ? s_rdata[SUMREC_W-1 -: CNT_W]
                : s_rdata[SUMREC_W-1 -: CNT_W] + CNT_W'(1);
    end

    assign q_clamp = (r_q > 16'(UNIT_ONE)) ? 16'(UNIT_ONE) : r_q;
    assign acc_idx = i_cmd.step - 6'd1;

    always_comb begin
        c_we    = (i_cmd.op == OP_LOAD) && idx_ok;
        c_waddr = AW'(r_idx);
        c_wdata = {r_in_c[2], r_in_c[1], r_in_c[0]};
        c_raddr = crn_addr;
        s_we    = 1'b0;
        s_waddr = crn_addr;
        s_wdata = {cnt_new, sum_new[2], sum_new[1], sum_new[0]};
        s_raddr = crn_addr;
        case (i_cmd.op)
            OP_CLEAR: begin
                s_we    = 1'b1;
                s_waddr = r_clr_addr;
                s_wdata = '0;
            end
            OP_RDSUM: begin
                s_raddr = AW'(r_idx);
            end
            OP_ACC: begin
                s_we = (i_cmd.step == 6'd1);
            end
            default: begin
            end
        endcase
    end

    mvn_ram #(.WIDTH(COORDREC_W), .DEPTH(VERTEX_SLOTS)) u_coord_ram (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(c_waddr),
        .i_wdata(c_wdata),
        .i_raddr(c_raddr),
        .o_rdata(c_rdata)
    );

    mvn_ram #(.WIDTH(SUMREC_W), .DEPTH(VERTEX_SLOTS)) u_sum_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == OP_EMIT) || (i_cmd.op == OP_EMIT_ZERO);
            if (i_cmd.op == OP_CLEAR) begin
                r_clr_addr <= (32'(r_clr_addr) == VERTEX_SLOTS - 1)
                            ? '0 : r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [MAG_W-1:0] ce;
        case (i_cmd.op)
            OP_LATCH: begin
                r_kind_read <= (t_cmd'(i_command) == CMD_READ);
                r_idx       <= i_vertex_index;
                r_crn[0]    <= i_corner_a;
                r_crn[1]    <= i_corner_b;
                r_crn[2]    <= i_corner_c;
                r_in_c[0]   <= i_coord_x;
                r_in_c[1]   <= i_coord_y;
                r_in_c[2]   <= i_coord_z;
                r_cnt       <= '0;
            end
            OP_COORD: begin
                for (int k = 1; k < 4; k++) begin
                    if (i_cmd.step[1:0] == 2'(k)) begin
                        for (int i = 0; i < 3; i++) begin
                            r_pt[k-1][i] <= c_rdata[i*COORD_W +: COORD_W];
                        end
                    end
                end
            end
            OP_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    r_v1[i] <= DIFF_W'(r_pt[1][i]) - DIFF_W'(r_pt[0][i]);
                    r_v2[i] <= DIFF_W'(r_pt[2][i]) - DIFF_W'(r_pt[1][i]);
                end
            end
            OP_CROSS: begin
                r_prod <= mul_p;
                if (i_cmd.step != 6'd0) begin
                    for (int i = 0; i < 3; i++) begin
                        if (acc_idx[2:1] == 2'(i)) begin
                            r_c[i] <= acc_idx[0] ? r_c[i] - CROSS_W'(r_prod)
                                                 : CROSS_W'(r_prod);
                        end
                    end
                end
            end
            OP_ABS: begin
                for (int i = 0; i < 3; i++) begin
                    if (i_cmd.sel == 2'd1) begin
                        ce = MAG_W'(sum_old[i]);
                    end else begin
                        ce = MAG_W'(r_c[i]);
                    end
                    r_neg[i] <= ce[MAG_W-1];
                    r_m[i]   <= ce[MAG_W-1] ? MAG_W'(-ce) : MAG_W'(ce);
                end
                if (i_cmd.sel == 2'd1) begin
                    r_cnt <= s_rdata[SUMREC_W-1 -: CNT_W];
                end
            end
            OP_MAX: begin
                if (r_m[0] >= r_m[1] && r_m[0] >= r_m[2]) begin
                    r_max <= r_m[0];
                end else if (r_m[1] >= r_m[2]) begin
                    r_max <= r_m[1];
                end else begin
                    r_max <= r_m[2];
                end
            end
            OP_SHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i] <= r_m[i] >> 1;
                end
                r_max <= r_max >> 1;
            end
            OP_SQ: begin
                for (int i = 0; i < 3; i++) begin
                    if (i_cmd.step[1:0] == 2'(i)) begin
                        r_sqp <= r_m[i][29:0] * r_m[i][29:0];
                    end
                end
                if (i_cmd.step == 6'd0) begin
                    r_sq <= '0;
                end else begin
                    r_sq <= r_sq + 62'(r_sqp);
                end
            end
            OP_SQRT: begin
                if (i_cmd.step == 6'd0) begin
                    r_x   <= 63'(r_sq);
                    r_res <= '0;
                    r_bit <= 63'(1) << 62;
                end else begin
                    if (r_x >= rb_sum) begin
                        r_x   <= r_x - rb_sum;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
            OP_DIV: begin
                if (i_cmd.step == 6'd0) begin
                    for (int i = 0; i < 3; i++) begin
                        if (i_cmd.sel == 2'(i)) begin
                            r_rem <= 46'({r_m[i][29:0], 14'd0}) + 46'(len >> 1);
                        end
                    end
                    r_dvs <= 47'(len) << 15;
                    r_q   <= '0;
                end else if (i_cmd.step == 6'(DIV_STEPS)) begin
                    for (int i = 0; i < 3; i++) begin
                        if (i_cmd.sel == 2'(i)) begin
                            r_n[i] <= r_neg[i] ? NORM_W'(-q_clamp) : NORM_W'(q_clamp);
                        end
                    end
                    r_zl <= 1'b0;
                end else begin
                    if (47'(r_rem) >= r_dvs) begin
                        r_rem <= 46'(47'(r_rem) - r_dvs);
                        r_q   <= {r_q[14:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[14:0], 1'b0};
                    end
                    r_dvs <= r_dvs >> 1;
                end
            end
            OP_SET_ZERO: begin
                for (int i = 0; i < 3; i++) begin
                    r_n[i] <= '0;
                end
                r_zl <= 1'b1;
            end
            OP_EMIT: begin
                r_o_kind <= r_kind_read;
                for (int i = 0; i < 3; i++) begin
                    r_o_n[i] <= r_n[i];
                end
                r_o_cnt <= r_cnt;
                r_o_zl  <= r_zl;
            end
            OP_EMIT_ZERO: begin
                r_o_kind <= r_kind_read;
                for (int i = 0; i < 3; i++) begin
                    r_o_n[i] <= '0;
                end
                r_o_cnt <= '0;
                r_o_zl  <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.clr_last   = (32'(r_clr_addr) == VERTEX_SLOTS - 1);
    assign o_sts.is_read    = r_kind_read;
    assign o_sts.idx_ok     = idx_ok;
    assign o_sts.crn_ok     = crn_ok;
    assign o_sts.cnt_zero   = (r_cnt == '0);
    assign o_sts.max_zero   = (r_max == '0);
    assign o_sts.shift_done = (r_max[MAG_W-1:30] == '0);
    assign o_sts.len_zero   = (r_res == '0);

    assign o_valid       = r_valid;
    assign o_result_kind = r_o_kind;
    assign o_normal_x    = r_o_n[0];
    assign o_normal_y    = r_o_n[1];
    assign o_normal_z    = r_o_n[2];
    assign o_use_count   = r_o_cnt;
    assign o_zero_length = r_o_zl;

endmodule

// File: design/mesh_vertex_normal_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_vertex_normal_engine
// A triangle may take longer when its cross products are wide; a degenerate
// triangle or a bad corner ends early, as does a vertex read whose sum cancels
// or whose vertex is unused. Load and clear hold busy; clear sweeps every slot.
// One transaction at a time; the 33-step square root and the three 18-step
// divisions dominate the work. Reset clears all sums and counts with a sweep
// over all VERTEX_SLOTS addresses while busy is high. Results are strobed for
// one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_engine
    import mvn_pkg::*;
#(
    parameter int VERTEX_SLOTS = VERTEX_SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_command,
    input  logic [9:0]                i_vertex_index,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    input  logic [10:0]               i_corner_a,
    input  logic [10:0]               i_corner_b,
    input  logic [10:0]               i_corner_c,
    output logic                      o_valid,
    output logic                      o_result_kind,
    output logic signed [NORM_W-1:0]  o_normal_x,
    output logic signed [NORM_W-1:0]  o_normal_y,
    output logic signed [NORM_W-1:0]  o_normal_z,
    output logic [CNT_W-1:0]          o_use_count,
    output logic                      o_zero_length
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mvn_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_command(i_command),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    mvn_datapath #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_command     (i_command),
        .i_vertex_index(i_vertex_index),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_corner_a    (i_corner_a),
        .i_corner_b    (i_corner_b),
        .i_corner_c    (i_corner_c),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_result_kind (o_result_kind),
        .o_normal_x    (o_normal_x),
        .o_normal_y    (o_normal_y),
        .o_normal_z    (o_normal_z),
        .o_use_count   (o_use_count),
        .o_zero_length (o_zero_length)
    );

endmodule

// File: design/mvn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_checker
// Port-level checks on the mesh vertex normal engine.
// ----------------------------------------------------------------------------
module mvn_checker
    import mvn_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      busy,
    input logic                      o_valid,
    input logic                      o_result_kind,
    input logic signed [NORM_W-1:0]  o_normal_x,
    input logic signed [NORM_W-1:0]  o_normal_y,
    input logic signed [NORM_W-1:0]  o_normal_z,
    input logic [CNT_W-1:0]          o_use_count,
    input logic                      o_zero_length
);

    a_reset_sweep: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy not raised for the clearing sweep after reset");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result strobes in consecutive cycles");

    a_zero_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_length) |->
        (o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0))
        else $error("zero-length result carries a nonzero normal");

    a_face_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result_kind) |-> (o_use_count == '0))
        else $error("face result carries a use count");

    a_read_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind && !o_zero_length) |-> (o_use_count != '0))
        else $error("normalized vertex read with zero use count");

endmodule

bind mesh_vertex_normal_engine mvn_checker u_mvn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_result_kind(o_result_kind),
    .o_normal_x   (o_normal_x),
    .o_normal_y   (o_normal_y),
    .o_normal_z   (o_normal_z),
    .o_use_count  (o_use_count),
    .o_zero_length(o_zero_length)
);
